### hw/rtl/pfam_pkg.sv
// Package for the prime field add/sub/mul block.
// Holds the pipeline payload type, cell kinds and operation codes; no dependencies.
package pfam_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned NumW   = 256;
  localparam int unsigned AccW   = NumW + 2;
  localparam int unsigned RedN   = NumW;
  localparam int unsigned MulN   = 2 * NumW;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_MUL_ALT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CELL_REDUCE = 2'd0,
    CELL_DOUBLE = 2'd1,
    CELL_ADD    = 2'd2,
    CELL_PASS   = 2'd3
  } cell_kind_e;

  typedef struct packed {
    logic            mul;
    logic            err;
    logic [AccW-1:0] acc;
    logic [AccW-1:0] x;
    logic [NumW-1:0] b;
  } stage_t;

endpackage

### hw/rtl/pfam_if.sv
// Request and response channel interfaces of the prime field block.
// Depends on nothing; widths follow the 64-bit word fields.
interface pfam_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] left_word_0;
  logic [63:0] left_word_1;
  logic [63:0] left_word_2;
  logic [63:0] left_word_3;
  logic [63:0] right_word_0;
  logic [63:0] right_word_1;
  logic [63:0] right_word_2;
  logic [63:0] right_word_3;
  modport source (output valid, op, left_word_0, left_word_1, left_word_2, left_word_3,
                  right_word_0, right_word_1, right_word_2, right_word_3, input ready);
  modport sink (input valid, op, left_word_0, left_word_1, left_word_2, left_word_3,
                right_word_0, right_word_1, right_word_2, right_word_3, output ready);
endinterface

interface pfam_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_word_0;
  logic [63:0] result_word_1;
  logic [63:0] result_word_2;
  logic [63:0] result_word_3;
  logic        operand_error;
  modport source (output valid, result_word_0, result_word_1, result_word_2, result_word_3,
                  operand_error, input ready);
  modport sink (input valid, result_word_0, result_word_1, result_word_2, result_word_3,
                operand_error, output ready);
endinterface

### hw/rtl/pfam_entry.sv
// Entry stage: operand check, modular add and subtract, setup of the multiply chain.
// Depends on pfam_pkg.
module pfam_entry (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic [1:0]                  op_i,
  input  logic [pfam_pkg::NumW-1:0]   a_i,
  input  logic [pfam_pkg::NumW-1:0]   b_i,
  input  logic [pfam_pkg::NumW-1:0]   mod_i,
  output logic                        valid_o,
  output pfam_pkg::stage_t            data_o
);
  logic [pfam_pkg::NumW:0]   sum;
  logic [pfam_pkg::NumW-1:0] add_res;
  logic [pfam_pkg::NumW-1:0] sub_res;
  logic                      valid_q;
  pfam_pkg::stage_t          data_d, data_q;

  always_comb begin
    sum = {1'b0, a_i} + {1'b0, b_i};
    if (sum >= {1'b0, mod_i}) begin
      sum = sum - {1'b0, mod_i};
    end
    add_res = sum[pfam_pkg::NumW-1:0];
    sub_res = a_i - b_i;
    if (a_i < b_i) begin
      sub_res = sub_res + mod_i;
    end
    data_d.mul = op_i[1];
    data_d.err = (a_i >= mod_i) || (b_i >= mod_i);
    data_d.x   = {2'b00, a_i};
    data_d.b   = b_i;
    if (op_i[1]) begin
      data_d.acc = '0;
    end else if (pfam_pkg::op_e'(op_i) == pfam_pkg::OP_SUB) begin
      data_d.acc = {2'b00, sub_res};
    end else begin
      data_d.acc = {2'b00, add_res};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

### hw/rtl/pfam_cell.sv
// One chain cell: a shift, add or pass step, then a conditional subtract for multiplies.
// Depends on pfam_pkg.
module pfam_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  pfam_pkg::cell_kind_e        kind_i,
  input  logic [pfam_pkg::NumW-1:0]   mod_i,
  input  logic                        valid_i,
  input  pfam_pkg::stage_t            data_i,
  output logic                        valid_o,
  output pfam_pkg::stage_t            data_o
);
  localparam int unsigned AW = pfam_pkg::AccW;
  localparam int unsigned NW = pfam_pkg::NumW;

  logic [AW-1:0]    sum;
  logic [AW-1:0]    m_ext;
  logic             valid_q;
  pfam_pkg::stage_t data_d, data_q;

  always_comb begin
    data_d = data_i;
    m_ext  = {2'b00, mod_i};
    case (kind_i)
      pfam_pkg::CELL_REDUCE: begin
        sum      = {data_i.acc[AW-2:0], data_i.x[NW-1]};
        data_d.x = {data_i.x[AW-2:0], 1'b0};
      end
      pfam_pkg::CELL_DOUBLE: begin
        sum = {data_i.acc[AW-2:0], 1'b0};
      end
      pfam_pkg::CELL_ADD: begin
        sum      = data_i.acc + (data_i.b[NW-1] ? data_i.x : '0);
        data_d.b = {data_i.b[NW-2:0], 1'b0};
      end
      default: begin
        sum = data_i.acc;
      end
    endcase
    if (data_i.mul) begin
      data_d.acc = (sum >= m_ext) ? sum - m_ext : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

### hw/rtl/prime_field_add_sub_mul_256_top.sv
// Prime field add, subtract and multiply over a modulus of up to 256 bits.
// Every operation passes through one entry stage, 256 cells that reduce the
// first operand, 512 cells of double-and-add over the second operand, one output register.
// Throughput is one request per cycle; the chain moves as a whole and stalls only
// while the output skid register is full. Reset clears all valid bits and the modulus.
// Depends on pfam_pkg, pfam_if, pfam_entry and pfam_cell.
module prime_field_add_sub_mul_256_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  pfam_req_if.sink    req_i,
  pfam_rsp_if.source  rsp_o
);
  localparam int unsigned NW    = pfam_pkg::NumW;
  localparam int unsigned RedN  = pfam_pkg::RedN;
  localparam int unsigned MulN  = pfam_pkg::MulN;
  localparam int unsigned Cells = RedN + MulN;

  // The modulus is held as four 64-bit configuration words.
  logic [63:0]   mod_q [4];
  logic [NW-1:0] modulus;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        mod_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      mod_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign modulus = {mod_q[3], mod_q[2], mod_q[1], mod_q[0]};

  // The whole chain advances together whenever the skid register is empty.
  logic adv;
  logic skid_valid_q, out_valid_q;
  pfam_pkg::stage_t skid_q, out_q;

  assign adv         = !skid_valid_q;
  assign req_i.ready = adv;

  logic             valid_s [Cells+1];
  pfam_pkg::stage_t data_s  [Cells+1];
  pfam_pkg::stage_t mul_in;

  pfam_entry u_entry (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (req_i.valid),
    .op_i    (req_i.op),
    .a_i     ({req_i.left_word_3, req_i.left_word_2, req_i.left_word_1, req_i.left_word_0}),
    .b_i     ({req_i.right_word_3, req_i.right_word_2, req_i.right_word_1,
               req_i.right_word_0}),
    .mod_i   (modulus),
    .valid_o (valid_s[0]),
    .data_o  (data_s[0])
  );

  // After the first operand is reduced, its residue becomes the addend and the
  // accumulator restarts at zero. Add and subtract results pass through untouched.
  always_comb begin
    mul_in = data_s[RedN];
    if (data_s[RedN].mul) begin
      mul_in.x   = data_s[RedN].acc;
      mul_in.acc = '0;
    end
  end

  for (genvar k = 0; k < Cells; k++) begin : g_cell
    pfam_pkg::cell_kind_e kind;
    pfam_pkg::stage_t     din;
    if (k < RedN) begin : g_red
      assign kind = pfam_pkg::CELL_REDUCE;
      assign din  = data_s[k];
    end else if (k == RedN) begin : g_first
      assign kind = pfam_pkg::CELL_DOUBLE;
      assign din  = mul_in;
    end else begin : g_mul
      assign kind = ((k - RedN) % 2 == 0) ? pfam_pkg::CELL_DOUBLE : pfam_pkg::CELL_ADD;
      assign din  = data_s[k];
    end
    pfam_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .kind_i  (kind),
      .mod_i   (modulus),
      .valid_i (valid_s[k]),
      .data_i  (din),
      .valid_o (valid_s[k+1]),
      .data_o  (data_s[k+1])
    );
  end

  // Output register plus one skid entry, so the chain keeps moving while a
  // result waits to be taken.
  logic out_fire;
  assign out_fire = out_valid_q && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (valid_s[Cells]) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (valid_s[Cells]) begin
      if (!out_valid_q || out_fire) begin
        out_q <= data_s[Cells];
      end else begin
        skid_q <= data_s[Cells];
      end
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_word_0 = out_q.acc[63:0];
  assign rsp_o.result_word_1 = out_q.acc[127:64];
  assign rsp_o.result_word_2 = out_q.acc[191:128];
  assign rsp_o.result_word_3 = out_q.acc[255:192];
  assign rsp_o.operand_error = out_q.err;
endmodule

### tb/sv/field_result_checker.sv
// Checker for the prime field add/sub/mul block: watches the config port and both channels.
// Predicts each response from the request and the modulus copy, compares in order.
// Depends on pfam_pkg and the channel interfaces in pfam_if.
module field_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  pfam_req_if         req,
  pfam_rsp_if         rsp,
  output int          fail_count_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [pfam_pkg::NumW-1:0] value;
    logic                      err;
  } field_result_t;

  logic [pfam_pkg::NumW-1:0] modulus;
  field_result_t             predicted_results[$];

  function automatic field_result_t field_op(logic [1:0] op, logic [pfam_pkg::NumW-1:0] a,
                                             logic [pfam_pkg::NumW-1:0] b,
                                             logic [pfam_pkg::NumW-1:0] m);
    field_result_t               r;
    logic [pfam_pkg::NumW:0]     s;
    logic [pfam_pkg::MulN-1:0]   p;
    r.err = (a >= m) || (b >= m);
    if (op == pfam_pkg::OP_MUL || op == pfam_pkg::OP_MUL_ALT) begin
      p = {{pfam_pkg::NumW{1'b0}}, a} * {{pfam_pkg::NumW{1'b0}}, b};
      if (m == '0) r.value = p[pfam_pkg::NumW-1:0];
      else begin
        p = p % {{pfam_pkg::NumW{1'b0}}, m};
        r.value = p[pfam_pkg::NumW-1:0];
      end
    end else if (op == pfam_pkg::OP_ADD) begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      r.value = s[pfam_pkg::NumW-1:0];
    end else begin
      r.value = (a >= b) ? a - b : a + m - b;
    end
    return r;
  endfunction

  task automatic report(string what, logic [pfam_pkg::NumW-1:0] got,
                        logic [pfam_pkg::NumW-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    modulus = '0;
  end

  assign outstanding_o = predicted_results.size();

  always @(posedge clk_i) begin
    field_result_t want;
    logic [pfam_pkg::NumW-1:0] got;
    if (rst_ni) begin
      if (cfg_we_i) modulus[cfg_idx_i*pfam_pkg::WordW +: pfam_pkg::WordW] = cfg_data_i;
      if (req.valid && req.ready) begin
        predicted_results.push_back(field_op(req.op,
          {req.left_word_3, req.left_word_2, req.left_word_1, req.left_word_0},
          {req.right_word_3, req.right_word_2, req.right_word_1, req.right_word_0}, modulus));
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.result_word_3, rsp.result_word_2, rsp.result_word_1, rsp.result_word_0};
        if (predicted_results.size() == 0) begin
          report("unexpected response", got, '0);
        end else begin
          want = predicted_results.pop_front();
          if (got !== want.value) report("result", got, want.value);
          if (rsp.operand_error !== want.err) begin
            report("operand_error", {{(pfam_pkg::NumW-1){1'b0}}, rsp.operand_error},
                   {{(pfam_pkg::NumW-1){1'b0}}, want.err});
          end
        end
      end
    end
  end
endmodule

### tb/sv/prime_field_add_sub_mul_256_top_tb.sv
// Testbench top for prime_field_add_sub_mul_256_top: clock, reset, stimulus and verdict.
// Depends on pfam_pkg, pfam_if, the block itself and field_result_checker.
module prime_field_add_sub_mul_256_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The main field prime, and a much smaller one.
  localparam logic [pfam_pkg::NumW-1:0] FieldPrime =
    256'd49885853761272603568320884710755151782187486770207743353506441985236025007921;
  localparam logic [pfam_pkg::NumW-1:0] TinyPrime = 256'd509;
  localparam logic [pfam_pkg::NumW-1:0] AllOnes = '1;
  localparam int PhaseItems = 76;
  // The pipeline is 770 stages deep; the wait at the end allows for a full pass.
  localparam int DrainCycles = 800;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_PRESSURE} idle_mode_e;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [63:0] cfg_data;
  int          fail_count;
  int          outstanding;
  idle_mode_e  idle_mode;
  int          hold_left;
  logic [pfam_pkg::NumW-1:0] modulus;

  pfam_req_if req_if();
  pfam_rsp_if rsp_if();

  prime_field_add_sub_mul_256_top dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .rsp_o     (rsp_if)
  );

  field_result_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .req          (req_if),
    .rsp          (rsp_if),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run normally ends well before this watchdog fires.
  initial begin
    #2ms;
    $display("[prime_field_add_sub_mul_256_top] ERROR");
    $finish;
  end

  // Response side. A long hold-off, once requested, overrides the stall pattern so that
  // the output and skid registers fill and the whole chain stops taking requests.
  initial begin
    rsp_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (idle_mode == IDLE_RECV) begin
        rsp_if.ready <= ($urandom_range(99) >= 71);
      end else if (idle_mode == IDLE_BOTH) begin
        rsp_if.ready <= ($urandom_range(99) >= 27);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Sets the modulus while the block is empty. The last request is withdrawn first; every
  // request yields a response, so an empty expectation queue means nothing is in flight.
  task automatic set_modulus(logic [pfam_pkg::NumW-1:0] m);
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= i[1:0];
      cfg_data <= m[i*64 +: 64];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    modulus = m;
  endtask

  // Offers one request after a gap chosen by the idle mode and holds it until accepted.
  task automatic send_request(logic [1:0] op, logic [pfam_pkg::NumW-1:0] a,
                              logic [pfam_pkg::NumW-1:0] b);
    int gap;
    gap = 0;
    if (idle_mode == IDLE_SEND) while ($urandom_range(99) < 71) gap++;
    else if (idle_mode == IDLE_BOTH) while ($urandom_range(99) < 27) gap++;
    else if (idle_mode == IDLE_PRESSURE) gap = $urandom_range(20);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.op <= op;
    {req_if.left_word_3, req_if.left_word_2, req_if.left_word_1, req_if.left_word_0} <= a;
    {req_if.right_word_3, req_if.right_word_2, req_if.right_word_1, req_if.right_word_0} <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  function automatic logic [pfam_pkg::NumW-1:0] random_word256();
    logic [pfam_pkg::NumW-1:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  // Operands are mostly reduced, with the boundary values and some raw ones mixed in.
  function automatic logic [pfam_pkg::NumW-1:0] random_operand();
    int pick;
    logic [pfam_pkg::NumW-1:0] v;
    pick = $urandom_range(99);
    v = random_word256();
    if (pick < 5) return '0;
    if (pick < 10) return modulus - 1;
    if (pick < 13) return modulus;
    if (pick < 23 || modulus == '0) return v;
    return v % modulus;
  endfunction

  function automatic logic [1:0] random_op();
    int pick;
    pick = $urandom_range(99);
    if (pick < 33) return pfam_pkg::OP_ADD;
    if (pick < 66) return pfam_pkg::OP_SUB;
    if (pick < 95) return pfam_pkg::OP_MUL;
    return pfam_pkg::OP_MUL_ALT;
  endfunction

  task automatic random_phase(logic [pfam_pkg::NumW-1:0] m, idle_mode_e mode);
    set_modulus(m);
    idle_mode = mode;
    if (mode == IDLE_PRESSURE) hold_left = 1200;
    repeat (PhaseItems) send_request(random_op(), random_operand(), random_operand());
  endtask

  initial begin
    logic [pfam_pkg::NumW-1:0] top_set;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    idle_mode = IDLE_NONE;
    modulus = '0;
    req_if.valid = 1'b0;
    req_if.op = pfam_pkg::OP_ADD;
    {req_if.left_word_3, req_if.left_word_2, req_if.left_word_1, req_if.left_word_0} = '0;
    {req_if.right_word_3, req_if.right_word_2, req_if.right_word_1, req_if.right_word_0} = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // A request against the reset modulus of zero: every operand is out of range.
    send_request(pfam_pkg::OP_MUL, AllOnes, 256'd3);

    // Directed requests at the field prime: the largest reduced operands for every
    // operation, wrap of the difference, operands at and above the modulus, and the
    // fourth operation code, which also multiplies.
    set_modulus(FieldPrime);
    send_request(pfam_pkg::OP_ADD, '0, '0);
    send_request(pfam_pkg::OP_ADD, FieldPrime - 1, FieldPrime - 1);
    send_request(pfam_pkg::OP_ADD, FieldPrime - 1, 256'd1);
    send_request(pfam_pkg::OP_SUB, '0, FieldPrime - 1);
    send_request(pfam_pkg::OP_SUB, FieldPrime - 1, '0);
    send_request(pfam_pkg::OP_SUB, 256'd5, 256'd5);
    send_request(pfam_pkg::OP_MUL, FieldPrime - 1, FieldPrime - 1);
    send_request(pfam_pkg::OP_MUL, '0, FieldPrime - 1);
    send_request(pfam_pkg::OP_MUL_ALT, FieldPrime - 1, 256'd2);
    send_request(pfam_pkg::OP_ADD, FieldPrime, '0);
    send_request(pfam_pkg::OP_SUB, '0, FieldPrime);
    send_request(pfam_pkg::OP_MUL, AllOnes, AllOnes);
    send_request(pfam_pkg::OP_ADD, AllOnes, AllOnes);
    send_request(pfam_pkg::OP_SUB, 256'd1, AllOnes);

    // The largest modulus: the sum can carry out of 256 bits.
    set_modulus(AllOnes);
    send_request(pfam_pkg::OP_ADD, AllOnes - 1, AllOnes - 1);
    send_request(pfam_pkg::OP_SUB, '0, AllOnes - 1);
    send_request(pfam_pkg::OP_MUL, AllOnes - 1, AllOnes - 1);
    send_request(pfam_pkg::OP_MUL_ALT, AllOnes, 256'd7);

    // Random phases over several moduli and every idling pattern. The pressure phase
    // keeps offering requests while the response side holds off for a long stretch.
    random_phase(FieldPrime, IDLE_NONE);
    random_phase(FieldPrime, IDLE_PRESSURE);
    random_phase(AllOnes, IDLE_SEND);
    random_phase('0, IDLE_RECV);
    random_phase(TinyPrime, IDLE_BOTH);
    top_set = random_word256();
    top_set[pfam_pkg::NumW-1] = 1'b1;
    random_phase(top_set, IDLE_RECV);
    random_phase(FieldPrime, IDLE_BOTH);

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("[prime_field_add_sub_mul_256_top] OK");
    end else begin
      $display("[prime_field_add_sub_mul_256_top] ERROR");
    end
    $finish;
  end
endmodule
